@@ sv/bsg_pkg.sv @@
// Shared types, constants and coefficient tables for the battery fuel gauge.
// Used by bsg_ctrl, bsg_dp and battery_soc_gauge; depends on nothing else.
`default_nettype none

package bsg_pkg;

	// State of charge is Q1.30; full charge is exactly 1.0.
	localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
	localparam logic [30:0] DEPLETE_LIMIT = 31'd10737418;
	localparam logic [30:0] CHARGE_RESET  = ONE_Q30;
	localparam logic [31:0] SCALE_RESET   = 32'd781874935;
	localparam logic [31:0] RETAIN_RESET  = 32'hFFFF_FFFF;

	localparam logic [18:0] OV_MAX = 19'h7FFFF;
	localparam logic [19:0] RS_MAX = 20'hFFFFF;

	// Configuration register indexes.
	localparam logic [1:0] REG_INITIAL_CHARGE = 2'd0;
	localparam logic [1:0] REG_CHARGE_SCALE   = 2'd1;
	localparam logic [1:0] REG_RETAIN_FACTOR  = 2'd2;

	// Polynomial select.
	localparam logic POLY_VOLT = 1'b0;
	localparam logic POLY_RES  = 1'b1;

	// Number of Horner steps after the leading coefficient.
	localparam logic [2:0] HORNER_STEPS = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMUL,
		ST_CHG,
		ST_RMUL,
		ST_RET,
		ST_SEED,
		ST_HMUL,
		ST_HACC,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_CHG,
		OP_RET,
		OP_SEED,
		OP_HACC,
		OP_FIN,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       poly;
		logic [2:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	// Voltage coefficients are Q24, resistance coefficients Q40, highest power first.
	function automatic logic signed [33:0] coef(input logic poly, input logic [2:0] k);
		logic signed [33:0] c;
		c = '0;
		case ({poly, k})
			{POLY_VOLT, 3'd0}: c = -34'sd312868712;
			{POLY_VOLT, 3'd1}: c =  34'sd749855321;
			{POLY_VOLT, 3'd2}: c = -34'sd614052331;
			{POLY_VOLT, 3'd3}: c =  34'sd210696961;
			{POLY_VOLT, 3'd4}: c =  34'sd34471230;
			{POLY_RES,  3'd0}: c = -34'sd500541673;
			{POLY_RES,  3'd1}: c =  34'sd1275697371;
			{POLY_RES,  3'd2}: c = -34'sd1009593567;
			{POLY_RES,  3'd3}: c =  34'sd194613558;
			{POLY_RES,  3'd4}: c =  34'sd113568556;
			default:           c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ sv/bsg_ctrl.sv @@
// Fuel gauge state machine: one datapath command per cycle, none while it waits.
// Depends on bsg_pkg for the state, command and status types and the constants.
`default_nettype none

module bsg_ctrl import bsg_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t     state_q, state_nxt;
	logic       poly_q;
	logic [2:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			poly_q  <= POLY_VOLT;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_RET:  poly_q <= POLY_VOLT;
				ST_SEED: step_q <= 3'd1;
				ST_HACC: step_q <= step_q + 3'd1;
				ST_FIN:  poly_q <= POLY_RES;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_CMUL;
			ST_CMUL: state_nxt = ST_CHG;
			ST_CHG:  state_nxt = ST_RMUL;
			ST_RMUL: state_nxt = ST_RET;
			ST_RET:  state_nxt = ST_SEED;
			ST_SEED: state_nxt = ST_HMUL;
			ST_HMUL: state_nxt = ST_HACC;
			ST_HACC: state_nxt = (step_q == HORNER_STEPS) ? ST_FIN : ST_HMUL;
			ST_FIN:  state_nxt = (poly_q == POLY_VOLT) ? ST_SEED : ST_OUT;
			ST_OUT:  if (stat.out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.poly = poly_q;
		cmd.step = step_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_CMUL: cmd.op = OP_MUL;
			ST_CHG:  cmd.op = OP_CHG;
			ST_RMUL: cmd.op = OP_MUL;
			ST_RET:  cmd.op = OP_RET;
			ST_SEED: cmd.op = OP_SEED;
			ST_HMUL: cmd.op = OP_MUL;
			ST_HACC: cmd.op = OP_HACC;
			ST_FIN:  cmd.op = OP_FIN;
			ST_OUT:  if (stat.out_free) cmd.op = OP_OUT;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/bsg_dp.sv @@
// Datapath of the fuel gauge: configuration, charge state, one shared 32x32 multiplier,
// Horner accumulator and the output register. Depends on bsg_pkg.
`default_nettype none

module bsg_dp import bsg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_stat_t                stat,
	input  wire logic               cfg_valid,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic signed [23:0] current,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [30:0]             charge_level,
	output logic [18:0]             open_voltage,
	output logic [19:0]             series_resistance,
	output logic                    depleted
);

	logic [31:0]        scale_q;
	logic [31:0]        retain_q;
	logic [30:0]        charge_q;
	logic signed [23:0] last_q;

	logic [31:0]        mag_q;
	logic               neg_q;
	logic [31:0]        mulb_q;
	logic [63:0]        prod_q;
	logic signed [33:0] acc_q;
	logic [18:0]        ov_q;
	logic [19:0]        rs_q;

	logic               out_valid_q;
	logic [30:0]        level_q;
	logic [18:0]        volt_q;
	logic [19:0]        res_q;
	logic               depl_q;

	// Trapezoid sum of this and the previous sample.
	logic signed [24:0] sum;
	logic [24:0]        sum_mag;
	assign sum     = 25'(current) + 25'(last_q);
	assign sum_mag = sum[24] ? 25'(-sum) : 25'(sum);

	// Charge update: t = charge -/+ round(|sum| * scale / 2^32), floored at zero.
	logic [63:0]        rnd32;
	logic [25:0]        dchg;
	logic signed [32:0] t_raw;
	logic [31:0]        t_cl;
	assign rnd32 = prod_q + 64'h0000_0000_8000_0000;
	assign dchg  = rnd32[57:32];
	assign t_raw = neg_q ? (33'({2'b00, charge_q}) + 33'(dchg))
	                     : (33'({2'b00, charge_q}) - 33'(dchg));
	assign t_cl  = t_raw[32] ? '0 : t_raw[31:0];

	// Self-discharge result, clamped to full charge.
	logic [31:0] soc_raw;
	logic [30:0] soc;
	assign soc_raw = rnd32[63:32];
	assign soc     = (soc_raw > 32'(ONE_Q30)) ? ONE_Q30 : soc_raw[30:0];

	// Horner step: acc = signed round(|acc| * soc / 2^30) + c[k].
	logic [63:0]        rnd30;
	logic [33:0]        hq;
	logic signed [33:0] hterm;
	logic signed [33:0] acc_new;
	logic signed [33:0] acc_abs;
	assign rnd30   = prod_q + 64'h0000_0000_2000_0000;
	assign hq      = rnd30[63:30];
	assign hterm   = neg_q ? -$signed(hq) : $signed(hq);
	assign acc_new = hterm + coef(cmd.poly, cmd.step);
	assign acc_abs = acc_new[33] ? -acc_new : acc_new;

	logic signed [33:0] seed;
	logic signed [33:0] seed_abs;
	assign seed     = coef(cmd.poly, 3'd0);
	assign seed_abs = seed[33] ? -seed : seed;

	// Final scaling by 2^-8 with saturation; a negative sum always ends at zero.
	logic [33:0] fin_rnd;
	logic [25:0] fin_val;
	logic [18:0] ov_sat;
	logic [19:0] rs_sat;
	assign fin_rnd = acc_q + 34'sd128;
	assign fin_val = fin_rnd[33:8];
	assign ov_sat  = acc_q[33] ? '0 : ((fin_val > 26'(OV_MAX)) ? OV_MAX : fin_val[18:0]);
	assign rs_sat  = acc_q[33] ? '0 : ((fin_val > 26'(RS_MAX)) ? RS_MAX : fin_val[19:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RESET;
			retain_q <= RETAIN_RESET;
			charge_q <= CHARGE_RESET;
			last_q   <= '0;
		end else begin
			if (cmd.op == OP_LOAD) last_q <= current;
			if (cmd.op == OP_RET) charge_q <= soc;
			if (cfg_valid) begin
				case (cfg_index)
					REG_INITIAL_CHARGE:
						charge_q <= (cfg_data[30:0] > ONE_Q30) ? ONE_Q30 : cfg_data[30:0];
					REG_CHARGE_SCALE:  scale_q  <= cfg_data;
					REG_RETAIN_FACTOR: retain_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Working registers hold payload only and need no reset.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				neg_q  <= sum[24];
				mag_q  <= 32'(sum_mag);
				mulb_q <= scale_q;
			end
			OP_MUL: prod_q <= mag_q * mulb_q;
			OP_CHG: begin
				neg_q  <= 1'b0;
				mag_q  <= t_cl;
				mulb_q <= retain_q;
			end
			OP_SEED: begin
				acc_q  <= seed;
				neg_q  <= seed[33];
				mag_q  <= seed_abs[31:0];
				mulb_q <= 32'(charge_q);
			end
			OP_HACC: begin
				acc_q <= acc_new;
				neg_q <= acc_new[33];
				mag_q <= acc_abs[31:0];
			end
			OP_FIN: begin
				if (cmd.poly == POLY_VOLT) ov_q <= ov_sat;
				else rs_q <= rs_sat;
			end
			OP_OUT: begin
				level_q <= charge_q;
				volt_q  <= ov_q;
				res_q   <= rs_q;
				depl_q  <= (charge_q <= DEPLETE_LIMIT);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free     = !out_valid_q || !out_stall;
	assign out_valid         = out_valid_q;
	assign charge_level      = level_q;
	assign open_voltage      = volt_q;
	assign series_resistance = res_q;
	assign depleted          = depl_q;

endmodule

`default_nettype wire

@@ sv/battery_soc_gauge.sv @@
// Coulomb-counting fuel gauge: one result per current sample.
// A sample is worked through in full before the next is taken: in_stall stays high from
// the load until the result is registered, and the next sample is taken back in idle.
// The pace is set by the single shared 32x32 multiplier: two charge products and two
// four-step Horner polynomials, each product followed by its update. A held result delays only the end.
// Reset (arst_n low) loads the register defaults, full charge and a zero previous sample.
`default_nettype none

module battery_soc_gauge import bsg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [23:0] current,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [30:0]             charge_level,
	output logic [18:0]             open_voltage,
	output logic [19:0]             series_resistance,
	output logic                    depleted
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Register writes are always accepted.
	assign cfg_ready = 1'b1;

	bsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bsg_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_valid         (cfg_valid),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.current           (current),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.charge_level      (charge_level),
		.open_voltage      (open_voltage),
		.series_resistance (series_resistance),
		.depleted          (depleted)
	);

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for battery_soc_gauge: current samples with random gaps and stalls.
// Depends on bsg_pkg and the gauge RTL; expected readings come from a fixed-point model below.

module testbench;
	import bsg_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 30;
	localparam int REPORT_LIMIT  = 10;
	localparam int SWEEP_ITEMS   = 111;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic signed [23:0] CURRENT_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] CURRENT_MIN = -24'sh800000;

	typedef struct packed {
		logic [30:0] charge_level;
		logic [18:0] open_voltage;
		logic [19:0] series_resistance;
		logic        depleted;
	} gauge_reading_t;

	typedef struct {
		logic [1:0]  index;
		logic [31:0] value;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic signed [23:0] current = '0;
	logic out_stall = 1'b0;
	logic cfg_ready, in_stall, out_valid, depleted;
	logic [30:0] charge_level;
	logic [18:0] open_voltage;
	logic [19:0] series_resistance;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int reading_count = 0;
	int quiet_cycles = 0;

	// Model state and register copies.
	logic [30:0] model_charge = CHARGE_RESET;
	logic signed [23:0] prev_current = '0;
	logic [30:0] set_initial = CHARGE_RESET;
	logic [31:0] set_scale = SCALE_RESET;
	logic [31:0] set_retain = RETAIN_RESET;
	longint poly_coef [2][5];

	gauge_reading_t expected_readings [$];
	gauge_reading_t oldest;
	reg_write_t pending_writes [$];

	battery_soc_gauge dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.current(current),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.charge_level(charge_level),
		.open_voltage(open_voltage),
		.series_resistance(series_resistance),
		.depleted(depleted)
	);

	always #5 clk = ~clk;

	// Decimal constant given as mantissa times 1e-8, rounded to nearest at 2^-sh.
	function automatic longint fixq(input longint mant, input int sh);
		return (mant * (longint'(1) << sh) + 50000000) / 100000000;
	endfunction

	// round(a * m / 2^sh) with ties away from zero.
	function automatic longint scaled_round(input longint a, input logic [63:0] m, input int sh);
		logic [63:0] a_abs;
		logic [127:0] mag;
		a_abs = (a < 0) ? -a : a;
		mag = {64'd0, a_abs} * {64'd0, m};
		mag = (mag + (128'd1 << (sh - 1))) >> sh;
		return (a < 0) ? -$signed(mag[63:0]) : $signed(mag[63:0]);
	endfunction

	function automatic longint poly_value(input logic which, input longint soc,
			input longint top);
		longint acc;
		acc = poly_coef[which][0];
		for (int k = 1; k < 5; k++)
			acc = scaled_round(acc, 64'(soc), 30) + poly_coef[which][k];
		acc = scaled_round(acc, 64'd1, 8);
		if (acc < 0)
			acc = 0;
		if (acc > top)
			acc = top;
		return acc;
	endfunction

	task automatic load_coefficients();
		poly_coef[POLY_VOLT][0] = -fixq(1864842845, 24);
		poly_coef[POLY_VOLT][1] =  fixq(64'd4469486002, 24);
		poly_coef[POLY_VOLT][2] = -fixq(64'd3660037106, 24);
		poly_coef[POLY_VOLT][3] =  fixq(1255851751, 24);
		poly_coef[POLY_VOLT][4] =  fixq(205464539, 24);
		poly_coef[POLY_RES][0]  = -fixq(45524, 40);
		poly_coef[POLY_RES][1]  =  fixq(116024, 40);
		poly_coef[POLY_RES][2]  = -fixq(91822, 40);
		poly_coef[POLY_RES][3]  =  fixq(17700, 40);
		poly_coef[POLY_RES][4]  =  fixq(10329, 40);
	endtask

	// Advances the charge model by one sample and queues the reading it produces.
	task automatic gauge_tick(input logic signed [23:0] cur);
		longint sum, t;
		logic [127:0] prod;
		logic [63:0] soc;
		gauge_reading_t r;
		sum = longint'(cur) + longint'(prev_current);
		t = longint'(model_charge) - scaled_round(sum, {32'd0, set_scale}, 32);
		prev_current = cur;
		if (t < 0)
			t = 0;
		prod = {64'd0, t} * {96'd0, set_retain} + (128'd1 << 31);
		soc = prod[95:32];
		if (soc > 64'(ONE_Q30))
			soc = 64'(ONE_Q30);
		model_charge = soc[30:0];
		r.charge_level = soc[30:0];
		r.open_voltage = 19'(poly_value(POLY_VOLT, longint'(soc), longint'(OV_MAX)));
		r.series_resistance = 20'(poly_value(POLY_RES, longint'(soc), longint'(RS_MAX)));
		r.depleted = (soc <= 64'(DEPLETE_LIMIT));
		expected_readings.push_back(r);
	endtask

	task automatic note_register(input logic [1:0] index, input logic [31:0] value);
		case (index)
			REG_INITIAL_CHARGE: begin
				set_initial = value[30:0];
				model_charge = (set_initial > ONE_Q30) ? ONE_Q30 : set_initial;
			end
			REG_CHARGE_SCALE: set_scale = value;
			REG_RETAIN_FACTOR: set_retain = value;
			default: ;
		endcase
	endtask

	task automatic send_current(input logic signed [23:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		current <= value;
		do @(posedge clk); while (in_stall !== 1'b0);
		gauge_tick(value);
	endtask

	// Stops sending and waits until every queued reading has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic stage_write(input logic [1:0] index, input logic [31:0] value);
		reg_write_t w;
		w.index = index;
		w.value = value;
		pending_writes.push_back(w);
	endtask

	// Register writes go back to back once the gauge is idle.
	task automatic apply_settings();
		reg_write_t w;
		drain();
		while (pending_writes.size() != 0) begin
			w = pending_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.index;
			cfg_data <= w.value;
			do @(posedge clk); while (cfg_ready !== 1'b1);
			note_register(w.index, w.value);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic set_gauge(input logic [31:0] initial_value, input logic [31:0] scale,
			input logic [31:0] retain);
		stage_write(REG_INITIAL_CHARGE, initial_value);
		stage_write(REG_CHARGE_SCALE, scale);
		stage_write(REG_RETAIN_FACTOR, retain);
		apply_settings();
	endtask

	function automatic logic signed [23:0] pick_current();
		case ($urandom_range(9))
			0: return '0;
			1: return CURRENT_MAX;
			2: return CURRENT_MIN;
			3, 4, 5: return 24'($urandom);
			default: return 24'($signed($urandom_range(8191)) - 4096);
		endcase
	endfunction

	function automatic logic [31:0] pick_initial();
		case ($urandom_range(3))
			0: return 32'd0;
			1: return 32'(ONE_Q30);
			2: return $urandom;
			default: return $urandom_range(32'(ONE_Q30));
		endcase
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return SCALE_RESET;
			3: return $urandom;
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	// Mostly close to one, so the charge survives long enough to move around.
	function automatic logic [31:0] pick_retain();
		case ($urandom_range(5))
			0: return RETAIN_RESET;
			1: return 32'd0;
			2: return $urandom;
			3: return RETAIN_RESET - $urandom_range(255);
			default: return RETAIN_RESET - $urandom_range(32'h10_0000);
		endcase
	endfunction

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic test_power_on_defaults();
		send_current(0);
		send_current(CURRENT_MIN);
		send_current(CURRENT_MIN);
		send_current(CURRENT_MAX);
		send_current(CURRENT_MAX);
		send_current(1);
		send_current(-1);
	endtask

	task automatic test_depletion_threshold();
		set_gauge(32'(DEPLETE_LIMIT), 32'd0, RETAIN_RESET);
		send_current(CURRENT_MAX);
		set_gauge(32'(DEPLETE_LIMIT) + 32'd1, 32'd0, RETAIN_RESET);
		send_current(CURRENT_MIN);
	endtask

	task automatic test_charge_clamps();
		// Bit 31 is dropped and the remaining value loads as full charge.
		set_gauge(32'hFFFF_FFFF, 32'hFFFF_FFFF, RETAIN_RESET);
		send_current(CURRENT_MIN);
		set_gauge(32'd1000, 32'hFFFF_FFFF, RETAIN_RESET);
		send_current(CURRENT_MAX);
		send_current(CURRENT_MAX);
		send_current(0);
	endtask

	task automatic test_retain_extremes();
		set_gauge(32'(ONE_Q30), 32'd0, 32'd0);
		send_current(5);
		set_gauge(32'(ONE_Q30), 32'd0, 32'h8000_0000);
		send_current(0);
		send_current(0);
	endtask

	task automatic test_unused_index();
		stage_write(REG_UNUSED, 32'hFFFF_FFFF);
		stage_write(REG_UNUSED, 32'd0);
		apply_settings();
		send_current(0);
		send_current(CURRENT_MAX);
	endtask

	task automatic test_random_sweep();
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: set_idling(23, 71);
				1: set_idling(71, 23);
				default: set_idling(0, 0);
			endcase
			for (int s = 0; s < 3; s++) begin
				set_gauge(pick_initial(), pick_scale(), pick_retain());
				for (int n = 0; n < SWEEP_ITEMS; n++)
					send_current(pick_current());
			end
		end
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			reading_count++;
			if (expected_readings.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("reading %0d arrived with nothing expected: level %0d",
						reading_count, charge_level);
			end else begin
				oldest = expected_readings.pop_front();
				if (oldest.charge_level !== charge_level ||
						oldest.open_voltage !== open_voltage ||
						oldest.series_resistance !== series_resistance ||
						oldest.depleted !== depleted) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("reading %0d: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
							reading_count, oldest.charge_level, oldest.open_voltage,
							oldest.series_resistance, oldest.depleted, charge_level,
							open_voltage, series_resistance, depleted);
				end
			end
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("battery_soc_gauge: mismatch");
				$finish;
			end
		end
	end

	initial begin
		load_coefficients();
		set_idling(23, 71);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_defaults();
		test_depletion_threshold();
		test_charge_clamps();
		test_retain_extremes();
		test_unused_index();
		test_random_sweep();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		fail_count += expected_readings.size();
		if (fail_count == 0)
			$display("battery_soc_gauge: match");
		else
			$display("battery_soc_gauge: mismatch");
		$finish;
	end

endmodule
